### rtl/qsf_pkg.sv
// Package with shared types, constants and fixed-point helpers for the shape function unit.
`timescale 1ns / 1ps
package qsf_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned OutW   = 20;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CntW   = 4;
  localparam int unsigned AccW   = 32;

  localparam logic [CntW-1:0] CountBilin = 4'd4;
  localparam logic [CntW-1:0] CountBiquad = 4'd9;

  // Input beat payload.
  typedef struct packed {
    logic signed [CoordW-1:0] xi;
    logic signed [CoordW-1:0] gamma;
  } qsf_in_t;

  // Result beat payload.
  typedef struct packed {
    logic [IdxW-1:0]        node_index;
    logic signed [OutW-1:0] shape_value;
    logic signed [OutW-1:0] deriv_xi;
    logic signed [OutW-1:0] deriv_gamma;
    logic                   bad_count;
    logic                   last_node;
  } qsf_out_t;

  // Saturate a 34-bit value to 32 bits.
  function automatic logic signed [AccW-1:0] sat32(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] hi;
    logic signed [AccW+1:0] lo;
    hi = {3'b000, {(AccW-1){1'b1}}};
    lo = {3'b111, {(AccW-1){1'b0}}};
    if (v > hi) begin
      return {1'b0, {(AccW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end
    return v[AccW-1:0];
  endfunction

  // Saturating negation.
  function automatic logic signed [AccW-1:0] ngt(input logic signed [AccW-1:0] a);
    return sat32(-{{2{a[AccW-1]}}, a});
  endfunction

  // Saturate to the output width.
  function automatic logic signed [OutW-1:0] pack20(input logic signed [AccW-1:0] v);
    if (v > 32'sd524287) begin
      return 20'sh7FFFF;
    end else if (v < -32'sd524288) begin
      return 20'sh80000;
    end
    return v[OutW-1:0];
  endfunction

endpackage

### rtl/qsf_stream_if.sv
// Valid/ready stream interface used by both channels.
`timescale 1ns / 1ps
interface qsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/qsf_cfg_if.sv
// Configuration write channel carrying the node count.
`timescale 1ns / 1ps
interface qsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/qsf_mul.sv
// Rounded, saturated fixed-point multiplier with one output register.
`timescale 1ns / 1ps
module qsf_mul #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [qsf_pkg::AccW-1:0] a_i,
  input  logic signed [qsf_pkg::AccW-1:0] b_i,
  output logic signed [qsf_pkg::AccW-1:0] p_o
);
  import qsf_pkg::*;

  logic signed [2*AccW-1:0] prod;
  logic signed [2*AccW-1:0] rnd;
  logic signed [2*AccW-1:0] shf;
  logic signed [AccW-1:0]   p_d;
  logic signed [AccW-1:0]   p_q;

  // Exact product, round half up, arithmetic shift, saturate.
  always_comb begin
    prod = a_i * b_i;
    rnd  = prod + (64'sd1 <<< (FRAC_BITS - 1));
    shf  = rnd >>> FRAC_BITS;
    if (shf > 64'sd2147483647) begin
      p_d = {1'b0, {(AccW-1){1'b1}}};
    end else if (shf < -64'sd2147483648) begin
      p_d = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      p_d = shf[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;
endmodule

### rtl/qsf_datapath.sv
// Pipelined evaluator: computes all node values for one point in five stages.
`timescale 1ns / 1ps
module qsf_datapath #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           in_valid_i,
  input  qsf_pkg::qsf_in_t               in_i,
  input  logic [qsf_pkg::CntW-1:0]       count_i,
  output logic                           out_valid_o,
  output logic [qsf_pkg::CntW-1:0]       out_count_o,
  output logic signed [qsf_pkg::AccW-1:0] n_o  [9],
  output logic signed [qsf_pkg::AccW-1:0] dx_o [9],
  output logic signed [qsf_pkg::AccW-1:0] dg_o [9]
);
  import qsf_pkg::*;

  localparam logic signed [AccW-1:0] One = AccW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [AccW-1:0] Qtr = AccW'(64'sd1 <<< (FRAC_BITS - 2));
  localparam logic signed [AccW-1:0] Hlf = AccW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam int unsigned NS = 5;

  logic [NS-1:0] vld_q;
  logic [CntW-1:0] cnt_q [NS];

  // Valid bits and node count travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q[0] <= count_i;
      for (int i = 1; i < NS; i++) begin
        cnt_q[i] <= cnt_q[i-1];
      end
    end
  end

  // Stage 1: sums and differences of the coordinates.
  logic signed [AccW-1:0] x1_q, g1_q, sp1_q, sm1_q, tp1_q, tm1_q;
  logic signed [AccW-1:0] s2_1_q, t2_1_q, s2m1_q, s2p1_q, t2m1_q, t2p1_q;
  always_ff @(posedge clk_i) begin
    logic signed [AccW+1:0] x, g, s2, t2;
    x  = {{(AccW+2-CoordW){in_i.xi[CoordW-1]}}, in_i.xi};
    g  = {{(AccW+2-CoordW){in_i.gamma[CoordW-1]}}, in_i.gamma};
    s2 = x + x;
    t2 = g + g;
    if (en_i) begin
      x1_q   <= x[AccW-1:0];
      g1_q   <= g[AccW-1:0];
      sp1_q  <= sat32(x + One);
      sm1_q  <= sat32(x - One);
      tp1_q  <= sat32(g + One);
      tm1_q  <= sat32(g - One);
      s2_1_q <= sat32(s2);
      t2_1_q <= sat32(t2);
      s2m1_q <= sat32(s2 - One);
      s2p1_q <= sat32(s2 + One);
      t2m1_q <= sat32(t2 - One);
      t2p1_q <= sat32(t2 + One);
    end
  end

  // Stage 2 multipliers: squares, cross term and first products.
  logic signed [AccW-1:0] ss2, tt2, st2;
  logic signed [AccW-1:0] a2 [4];  // sm*tm sp*tm sp*tp sm*tp
  logic signed [AccW-1:0] q2 [8];  // qtr of tm tp sm sp, hlf unused
  logic signed [AccW-1:0] gx2 [4]; // tm*g tp*g sp*x sm*x
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_ss (.clk_i, .en_i, .a_i(x1_q), .b_i(x1_q), .p_o(ss2));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_tt (.clk_i, .en_i, .a_i(g1_q), .b_i(g1_q), .p_o(tt2));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_st (.clk_i, .en_i, .a_i(x1_q), .b_i(g1_q), .p_o(st2));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_a0 (.clk_i, .en_i, .a_i(sm1_q), .b_i(tm1_q), .p_o(a2[0]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_a1 (.clk_i, .en_i, .a_i(sp1_q), .b_i(tm1_q), .p_o(a2[1]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_a2 (.clk_i, .en_i, .a_i(sp1_q), .b_i(tp1_q), .p_o(a2[2]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_a3 (.clk_i, .en_i, .a_i(sm1_q), .b_i(tp1_q), .p_o(a2[3]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_q0 (.clk_i, .en_i, .a_i(tm1_q), .b_i(Qtr), .p_o(q2[0]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_q1 (.clk_i, .en_i, .a_i(tp1_q), .b_i(Qtr), .p_o(q2[1]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_q2 (.clk_i, .en_i, .a_i(sm1_q), .b_i(Qtr), .p_o(q2[2]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_q3 (.clk_i, .en_i, .a_i(sp1_q), .b_i(Qtr), .p_o(q2[3]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_g0 (.clk_i, .en_i, .a_i(tm1_q), .b_i(g1_q), .p_o(gx2[0]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_g1 (.clk_i, .en_i, .a_i(tp1_q), .b_i(g1_q), .p_o(gx2[1]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_g2 (.clk_i, .en_i, .a_i(sp1_q), .b_i(x1_q), .p_o(gx2[2]));
  qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_g3 (.clk_i, .en_i, .a_i(sm1_q), .b_i(x1_q), .p_o(gx2[3]));
  assign q2[4] = '0;
  assign q2[5] = '0;
  assign q2[6] = '0;
  assign q2[7] = '0;

  // Carry stage-1 terms alongside stage 2.
  logic signed [AccW-1:0] sp2_q, sm2_q, tp2_q, tm2_q, s2_2_q, t2_2_q;
  logic signed [AccW-1:0] s2m2_q, s2p2_q, t2m2_q, t2p2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp2_q <= sp1_q; sm2_q <= sm1_q; tp2_q <= tp1_q; tm2_q <= tm1_q;
      s2_2_q <= s2_1_q; t2_2_q <= t2_1_q;
      s2m2_q <= s2m1_q; s2p2_q <= s2p1_q; t2m2_q <= t2m1_q; t2p2_q <= t2p1_q;
    end
  end

  logic signed [AccW-1:0] omss2, omtt2;
  assign omss2 = sat32(One - {{2{ss2[AccW-1]}}, ss2});
  assign omtt2 = sat32(One - {{2{tt2[AccW-1]}}, tt2});

  // Stage 3 multipliers: second factor of each product.
  logic signed [AccW-1:0] m3 [30];
  logic signed [AccW-1:0] ma [30];
  logic signed [AccW-1:0] mb [30];
  always_comb begin
    // biquad corner values: (sm*st)... use (sm,st),(sp,st)... first product
    ma[0]  = sm2_q;  mb[0]  = st2;
    ma[1]  = sp2_q;  mb[1]  = st2;
    ma[2]  = gx2[0]; mb[2]  = omss2;   // tm*g*omss
    ma[3]  = gx2[2]; mb[3]  = omtt2;   // sp*x*omtt
    ma[4]  = gx2[1]; mb[4]  = omss2;
    ma[5]  = gx2[3]; mb[5]  = omtt2;
    ma[6]  = omss2;  mb[6]  = omtt2;   // n8
    ma[7]  = gx2[0]; mb[7]  = s2m2_q;
    ma[8]  = gx2[0]; mb[8]  = s2p2_q;
    ma[9]  = gx2[1]; mb[9]  = s2p2_q;
    ma[10] = gx2[1]; mb[10] = s2m2_q;
    ma[11] = gx2[3]; mb[11] = t2m2_q;
    ma[12] = gx2[2]; mb[12] = t2m2_q;
    ma[13] = gx2[2]; mb[13] = t2p2_q;
    ma[14] = gx2[3]; mb[14] = t2p2_q;
    ma[15] = st2;    mb[15] = tm2_q;
    ma[16] = omtt2;  mb[16] = s2p2_q;
    ma[17] = st2;    mb[17] = tp2_q;
    ma[18] = omtt2;  mb[18] = s2m2_q;
    ma[19] = omss2;  mb[19] = t2m2_q;
    ma[20] = st2;    mb[20] = sp2_q;
    ma[21] = omss2;  mb[21] = t2p2_q;
    ma[22] = st2;    mb[22] = sm2_q;
    ma[23] = s2_2_q; mb[23] = omtt2;
    ma[24] = t2_2_q; mb[24] = omss2;
    // bilinear: qtr of corner products
    ma[25] = a2[0];  mb[25] = Qtr;
    ma[26] = a2[1];  mb[26] = Qtr;
    ma[27] = a2[2];  mb[27] = Qtr;
    ma[28] = a2[3];  mb[28] = Qtr;
    ma[29] = '0;     mb[29] = '0;
  end

  for (genvar i = 0; i < 30; i++) begin : g_m3
    qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_m (.clk_i, .en_i, .a_i(ma[i]), .b_i(mb[i]), .p_o(m3[i]));
  end

  // Carry values needed later.
  logic signed [AccW-1:0] tm3_q, tp3_q, q3_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tm3_q <= tm2_q;
      tp3_q <= tp2_q;
      for (int i = 0; i < 4; i++) begin
        q3_q[i] <= q2[i];
      end
    end
  end

  // Stage 4 multipliers: third factor or scale.
  logic signed [AccW-1:0] m4 [30];
  logic signed [AccW-1:0] ca [30];
  logic signed [AccW-1:0] cb [30];
  always_comb begin
    ca[0]  = m3[0];  cb[0]  = tm3_q;  // sm*st*tm
    ca[1]  = m3[1];  cb[1]  = tm3_q;
    ca[2]  = m3[1];  cb[2]  = tp3_q;
    ca[3]  = m3[0];  cb[3]  = tp3_q;
    ca[4]  = m3[2];  cb[4]  = Hlf;
    ca[5]  = m3[3];  cb[5]  = Hlf;
    ca[6]  = m3[4];  cb[6]  = Hlf;
    ca[7]  = m3[5];  cb[7]  = Hlf;
    ca[8]  = m3[7];  cb[8]  = Qtr;
    ca[9]  = m3[8];  cb[9]  = Qtr;
    ca[10] = m3[9];  cb[10] = Qtr;
    ca[11] = m3[10]; cb[11] = Qtr;
    ca[12] = m3[11]; cb[12] = Qtr;
    ca[13] = m3[12]; cb[13] = Qtr;
    ca[14] = m3[13]; cb[14] = Qtr;
    ca[15] = m3[14]; cb[15] = Qtr;
    ca[16] = m3[16]; cb[16] = Hlf;
    ca[17] = m3[18]; cb[17] = Hlf;
    ca[18] = m3[19]; cb[18] = Hlf;
    ca[19] = m3[21]; cb[19] = Hlf;
    for (int i = 20; i < 30; i++) begin
      ca[i] = '0;
      cb[i] = '0;
    end
  end

  for (genvar i = 0; i < 20; i++) begin : g_m4
    qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_m (.clk_i, .en_i, .a_i(ca[i]), .b_i(cb[i]), .p_o(m4[i]));
  end
  for (genvar i = 20; i < 30; i++) begin : g_m4z
    assign m4[i] = '0;
  end

  // Carry stage-3 results that are finished.
  logic signed [AccW-1:0] c4_q [16];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q[0]  <= m3[6];
      c4_q[1]  <= ngt(m3[15]);
      c4_q[2]  <= ngt(m3[17]);
      c4_q[3]  <= ngt(m3[20]);
      c4_q[4]  <= ngt(m3[22]);
      c4_q[5]  <= ngt(m3[23]);
      c4_q[6]  <= ngt(m3[24]);
      c4_q[7]  <= m3[25];
      c4_q[8]  <= ngt(m3[26]);
      c4_q[9]  <= m3[27];
      c4_q[10] <= ngt(m3[28]);
      for (int i = 0; i < 4; i++) begin
        c4_q[11+i] <= q3_q[i];
      end
      c4_q[15] <= m3[29];
    end
  end

  // Stage 5 multipliers: quarter scale of the corner values.
  logic signed [AccW-1:0] m5 [4];
  for (genvar i = 0; i < 4; i++) begin : g_m5
    qsf_mul #(.FRAC_BITS(FRAC_BITS)) u_m (.clk_i, .en_i, .a_i(m4[i]), .b_i(Qtr), .p_o(m5[i]));
  end

  // Carry the rest into stage 5 and select by node count.
  logic signed [AccW-1:0] r5_q [16];
  logic signed [AccW-1:0] c5_q [16];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 16; i++) begin
        r5_q[i] <= m4[4+i];
        c5_q[i] <= c4_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      n_o[i] = '0; dx_o[i] = '0; dg_o[i] = '0;
    end
    if (cnt_q[NS-1] == CountBilin) begin
      n_o[0]  = c5_q[7];  n_o[1]  = c5_q[8];
      n_o[2]  = c5_q[9];  n_o[3]  = c5_q[10];
      dx_o[0] = c5_q[11]; dx_o[1] = ngt(c5_q[11]);
      dx_o[2] = c5_q[12]; dx_o[3] = ngt(c5_q[12]);
      dg_o[0] = c5_q[13]; dg_o[1] = ngt(c5_q[14]);
      dg_o[2] = c5_q[14]; dg_o[3] = ngt(c5_q[13]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        n_o[i]    = m5[i];
        n_o[4+i]  = r5_q[i];
        dx_o[i]   = r5_q[4+i];
        dg_o[i]   = r5_q[8+i];
      end
      n_o[8]  = c5_q[0];
      dx_o[4] = c5_q[1];  dx_o[5] = r5_q[12];
      dx_o[6] = c5_q[2];  dx_o[7] = r5_q[13];
      dg_o[4] = r5_q[14]; dg_o[5] = c5_q[3];
      dg_o[6] = r5_q[15]; dg_o[7] = c5_q[4];
      dx_o[8] = c5_q[5];  dg_o[8] = c5_q[6];
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_count_o = cnt_q[NS-1];
endmodule

### rtl/qsf_serializer.sv
// Buffers one evaluated point and emits its node results one beat per cycle while out_if is ready.
`timescale 1ns / 1ps
module qsf_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [qsf_pkg::CntW-1:0]        count_i,
  input  logic signed [qsf_pkg::AccW-1:0] n_i  [9],
  input  logic signed [qsf_pkg::AccW-1:0] dx_i [9],
  input  logic signed [qsf_pkg::AccW-1:0] dg_i [9],
  output logic                            busy_o,
  output logic                            done_o,
  qsf_stream_if.source                    out_if
);
  import qsf_pkg::*;

  logic                   busy_q;
  logic [IdxW-1:0]        idx_q;
  logic [IdxW-1:0]        last_q;
  logic                   bad_q;
  logic signed [AccW-1:0] n_q  [9];
  logic signed [AccW-1:0] dx_q [9];
  logic signed [AccW-1:0] dg_q [9];
  logic                   fire;

  assign fire   = out_if.valid && out_if.ready;
  assign done_o = fire && (idx_q == last_q);
  assign busy_o = busy_q;

  // Node counter and point buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bad_q  <= (count_i != CountBilin) && (count_i != CountBiquad);
      last_q <= (count_i == CountBiquad) ? 4'd8 : (count_i == CountBilin) ? 4'd3 : 4'd0;
      n_q    <= n_i;
      dx_q   <= dx_i;
      dg_q   <= dg_i;
    end
  end

  // Result beat.
  logic [3:0] sel;
  assign sel = (idx_q > 4'd8) ? 4'd8 : idx_q;
  always_comb begin
    out_if.valid            = busy_q;
    out_if.data.node_index  = idx_q;
    out_if.data.shape_value = bad_q ? '0 : pack20(n_q[sel]);
    out_if.data.deriv_xi    = bad_q ? '0 : pack20(dx_q[sel]);
    out_if.data.deriv_gamma = bad_q ? '0 : pack20(dg_q[sel]);
    out_if.data.bad_count   = bad_q;
    out_if.data.last_node   = (idx_q == last_q);
  end
endmodule

### rtl/quad_shape_function_eval_unit.sv
// Top level of the quadrilateral shape function evaluator.
//   channel   dir  payload                                 handshake
//   cfg_if    in   node_count[3:0]                         valid/ready
//   in_if     in   xi[15:0], gamma[15:0]                   valid/ready
//   out_if    out  node_index, shape_value, deriv_xi,      valid/ready
//                  deriv_gamma, bad_count, last_node
// A point passes a five-stage multiplier pipeline, then a buffer emits one node beat
// per cycle if ready: 4 beats per point for 4 nodes, 9 for 9 nodes, 1 for a bad count.
// The result port therefore sets the rate; the pipeline holds several points meanwhile.
// The pipeline advances when its last stage is empty or the buffer takes it; a stall
// freezes every stage. Reset clears valid bits, the buffer and sets node_count to 4.
`timescale 1ns / 1ps
module quad_shape_function_eval_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qsf_cfg_if.sink     cfg_if,
  qsf_stream_if.sink  in_if,
  qsf_stream_if.source out_if
);
  import qsf_pkg::*;

  logic [CntW-1:0] count_q;
  logic            en;
  logic            load;
  logic            busy;
  logic            done;
  logic            pipe_valid;
  logic [CntW-1:0] pipe_count;
  logic signed [AccW-1:0] n  [9];
  logic signed [AccW-1:0] dx [9];
  logic signed [AccW-1:0] dg [9];

  // Configuration register.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountBilin;
    end else if (cfg_if.valid) begin
      count_q <= cfg_if.data;
    end
  end

  // Buffer takes the pipeline output when empty or finishing.
  assign load        = pipe_valid && (!busy || done);
  assign en          = !pipe_valid || load;
  assign in_if.ready = en;

  qsf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(in_if.valid && en), .in_i(in_if.data),
    .count_i(count_q), .out_valid_o(pipe_valid), .out_count_o(pipe_count),
    .n_o(n), .dx_o(dx), .dg_o(dg)
  );

  qsf_serializer u_ser (
    .clk_i, .rst_ni, .load_i(load), .count_i(pipe_count), .n_i(n), .dx_i(dx), .dg_i(dg),
    .busy_o(busy), .done_o(done), .out_if(out_if)
  );
endmodule

### tb/quad_shape_function_eval_unit_tb.sv
// Self-checking testbench for the quadrilateral shape function evaluator.
`timescale 1ns / 1ps
module quad_shape_function_eval_unit_tb;
  import qsf_pkg::*;

  localparam int FB = 14;
  localparam longint ONE = 64'sd1 <<< FB;

  // Expected node beats, predicted from each accepted point.
  class shape_scoreboard;
    qsf_out_t node_beats[$];
    logic [3:0] node_count;
    int errors;

    function new();
      node_count = CountBilin;
      errors = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Rounded fixed-point product, ties toward plus infinity.
    function longint fmul(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< (FB - 1));
      return clip32(p >>> FB);
    endfunction

    function longint fmul3(longint a, longint b, longint c);
      return fmul(fmul(a, b), c);
    endfunction

    function longint quarter(longint a);
      return fmul(a, 64'sd1 <<< (FB - 2));
    endfunction

    function longint half(longint a);
      return fmul(a, 64'sd1 <<< (FB - 1));
    endfunction

    function longint negate(longint a);
      return clip32(-a);
    endfunction

    function logic signed [19:0] clip20(longint v);
      if (v > 64'sd524287) return 20'sh7FFFF;
      if (v < -64'sd524288) return 20'sh80000;
      return v[19:0];
    endfunction

    function void note_point(logic signed [15:0] xi, logic signed [15:0] gam);
      longint x, g, sp, sm, tp, tm, s2, t2, ss, tt, st, omss, omtt, s2m, s2p, t2m, t2p;
      longint n[9], dx[9], dg[9];
      int cnt;
      qsf_out_t b;
      x = xi;
      g = gam;
      sp = clip32(x + ONE);
      sm = clip32(x - ONE);
      tp = clip32(g + ONE);
      tm = clip32(g - ONE);
      if (node_count == CountBilin) begin
        cnt = 4;
        n[0] = quarter(fmul(sm, tm));
        n[1] = negate(quarter(fmul(sp, tm)));
        n[2] = quarter(fmul(sp, tp));
        n[3] = negate(quarter(fmul(sm, tp)));
        dx[0] = quarter(tm);
        dx[1] = negate(quarter(tm));
        dx[2] = quarter(tp);
        dx[3] = negate(quarter(tp));
        dg[0] = quarter(sm);
        dg[1] = negate(quarter(sp));
        dg[2] = quarter(sp);
        dg[3] = negate(quarter(sm));
      end else if (node_count == CountBiquad) begin
        cnt = 9;
        s2 = clip32(2 * x);
        t2 = clip32(2 * g);
        ss = fmul(x, x);
        tt = fmul(g, g);
        st = fmul(x, g);
        omss = clip32(ONE - ss);
        omtt = clip32(ONE - tt);
        s2m = clip32(s2 - ONE);
        s2p = clip32(s2 + ONE);
        t2m = clip32(t2 - ONE);
        t2p = clip32(t2 + ONE);
        n[0] = quarter(fmul3(sm, st, tm));
        n[1] = quarter(fmul3(sp, st, tm));
        n[2] = quarter(fmul3(sp, st, tp));
        n[3] = quarter(fmul3(sm, st, tp));
        n[4] = half(fmul3(tm, g, omss));
        n[5] = half(fmul3(sp, x, omtt));
        n[6] = half(fmul3(tp, g, omss));
        n[7] = half(fmul3(sm, x, omtt));
        n[8] = fmul(omss, omtt);
        dx[0] = quarter(fmul3(tm, g, s2m));
        dx[1] = quarter(fmul3(tm, g, s2p));
        dx[2] = quarter(fmul3(tp, g, s2p));
        dx[3] = quarter(fmul3(tp, g, s2m));
        dg[0] = quarter(fmul3(sm, x, t2m));
        dg[1] = quarter(fmul3(sp, x, t2m));
        dg[2] = quarter(fmul3(sp, x, t2p));
        dg[3] = quarter(fmul3(sm, x, t2p));
        dx[4] = negate(fmul(st, tm));
        dx[5] = half(fmul(omtt, s2p));
        dx[6] = negate(fmul(st, tp));
        dx[7] = half(fmul(omtt, s2m));
        dg[4] = half(fmul(omss, t2m));
        dg[5] = negate(fmul(st, sp));
        dg[6] = half(fmul(omss, t2p));
        dg[7] = negate(fmul(st, sm));
        dx[8] = negate(fmul(s2, omtt));
        dg[8] = negate(fmul(t2, omss));
      end else begin
        // Unsupported node count gives a single flagged beat.
        b = '0;
        b.bad_count = 1'b1;
        b.last_node = 1'b1;
        node_beats.push_back(b);
        return;
      end
      for (int k = 0; k < cnt; k++) begin
        b.node_index = k[3:0];
        b.shape_value = clip20(n[k]);
        b.deriv_xi = clip20(dx[k]);
        b.deriv_gamma = clip20(dg[k]);
        b.bad_count = 1'b0;
        b.last_node = (k == cnt - 1);
        node_beats.push_back(b);
      end
    endfunction

    function void check_beat(qsf_out_t got);
      qsf_out_t want;
      if (node_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: node %0d", got.node_index);
        return;
      end
      want = node_beats.pop_front();
      if (got.node_index !== want.node_index || got.shape_value !== want.shape_value ||
          got.deriv_xi !== want.deriv_xi || got.deriv_gamma !== want.deriv_gamma ||
          got.bad_count !== want.bad_count || got.last_node !== want.last_node) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp idx=%0d n=%0d dx=%0d dg=%0d bad=%0b last=%0b",
                   want.node_index, want.shape_value, want.deriv_xi, want.deriv_gamma,
                   want.bad_count, want.last_node);
          $display("         got idx=%0d n=%0d dx=%0d dg=%0d bad=%0b last=%0b",
                   got.node_index, got.shape_value, got.deriv_xi, got.deriv_gamma,
                   got.bad_count, got.last_node);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  shape_scoreboard sb = new();

  qsf_cfg_if cfg_if ();
  qsf_stream_if #(.payload_t(qsf_in_t)) in_if ();
  qsf_stream_if #(.payload_t(qsf_out_t)) out_if ();

  quad_shape_function_eval_unit #(.FRAC_BITS(FB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls and a check of every accepted beat.
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.data);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_count(logic [3:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.node_count = v;
  endtask

  // Sends one point; valid stays high when no gap precedes the next one.
  task automatic send_point(logic signed [15:0] xi, logic signed [15:0] gam);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{xi: xi, gamma: gam};
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_point(xi, gam);
  endtask

  // Waits until every expected beat has come, then lets the pipeline settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.node_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      6, 7: return 16'($urandom);
      8: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      9: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  logic signed [15:0] corner_xi[10] = '{0, 16384, -16384, 16384, -16384, 32767, -32768,
                                        32767, 8192, 1};
  logic signed [15:0] corner_g[10] = '{0, 16384, -16384, -16384, 16384, 32767, -32768,
                                       -32768, -8192, -1};
  logic [3:0] phase_count[8] = '{9, 4, 15, 9, 0, 4, 9, 7};

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset count, then biquadratic, then a bad count.
    for (int i = 0; i < 10; i++) send_point(corner_xi[i], corner_g[i]);
    drain();
    write_count(CountBiquad);
    for (int i = 0; i < 10; i++) send_point(corner_xi[i], corner_g[i]);
    drain();
    write_count(4'd0);
    send_point(16'sd100, -16'sd100);
    send_point(16'sh7FFF, 16'sh8000);
    drain();

    // Random phases across counts and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_count(phase_count[ph]);
      for (int i = 0; i < 24; i++) begin
        if (ph == 3 && i == 12) drain();
        send_point(pick_coord(), pick_coord());
      end
      drain();
    end
    write_count(CountBilin);
    send_point(pick_coord(), pick_coord());
    drain();

    if (sb.errors == 0 && sb.node_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
